@@ sv/modbus_rtu_frame_receiver_defines.svh @@
// Assertion macros for the Modbus RTU frame receiver.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef MODBUS_RTU_FRAME_RECEIVER_DEFINES_SVH
`define MODBUS_RTU_FRAME_RECEIVER_DEFINES_SVH

// The condition implies the consequence in the same cycle.
`define MRTU_ASSERT_NOW(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("mrtu: same-cycle check failed");

// The condition implies the consequence in the following cycle.
`define MRTU_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("mrtu: next-cycle check failed");

`endif

@@ sv/mrtu_pkg.sv @@
// Shared types, codes and the CRC-16 byte update for the Modbus RTU receiver.
// No dependencies.
package mrtu_pkg;

	localparam int MAX_FRAME_DEF = 256;
	localparam int MIN_FRAME     = 4;
	localparam int HDR_CRC_BYTES = 3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] OWN_ADDR_RST = 8'd1;
	localparam logic [7:0] BCAST_ADDR   = 8'd0;

	localparam logic [1:0] ST_ACCEPTED  = 2'd0;
	localparam logic [1:0] ST_TOO_SHORT = 2'd1;
	localparam logic [1:0] ST_CRC_ERROR = 2'd2;
	localparam logic [1:0] ST_NOT_ADDR  = 2'd3;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] frame_address;
		logic [7:0] function_code;
		logic [7:0] pdu_length;
		logic       is_broadcast;
	} out_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ sv/mrtu_classify.sv @@
// Classifies a completed frame from the receive state into one result.
// Depends on mrtu_pkg.
module mrtu_classify #(
	parameter int CW = 9
) (
	input  logic [CW-1:0] byte_count,
	input  logic [15:0]   running_crc,
	input  logic [7:0]    held_address,
	input  logic [7:0]    held_function,
	input  logic [7:0]    own_address,
	output mrtu_pkg::out_t result
);

	logic [CW-1:0] plen_full;
	logic          short_frame;
	logic          addressed;

	assign plen_full   = byte_count - CW'(mrtu_pkg::HDR_CRC_BYTES);
	assign short_frame = byte_count < CW'(mrtu_pkg::MIN_FRAME);
	assign addressed   = (held_address == own_address) || (held_address == mrtu_pkg::BCAST_ADDR);

	always_comb begin
		result.frame_address = held_address;
		result.function_code = held_function;
		result.is_broadcast  = held_address == mrtu_pkg::BCAST_ADDR;
		result.pdu_length    = short_frame ? 8'd0 : 8'(plen_full);
		if (short_frame) begin
			result.status = mrtu_pkg::ST_TOO_SHORT;
		end else if (running_crc != 16'h0000) begin
			result.status = mrtu_pkg::ST_CRC_ERROR;
		end else if (!addressed) begin
			result.status = mrtu_pkg::ST_NOT_ADDR;
		end else begin
			result.status = mrtu_pkg::ST_ACCEPTED;
		end
	end

endmodule

@@ sv/modbus_rtu_frame_receiver.sv @@
// Modbus RTU receive side: one transaction per cycle, bytes or silence timeouts.
// A timeout that ends a frame shows its result in the cycle after it is accepted.
// Throughput is one item per clock; the byte-wide CRC update and the frame
// classification are both combinational, and only a frame-ending
// timeout waits while an earlier result is still untaken.
// Asynchronous active-low reset: init mode, address register 1, no result held.
`include "modbus_rtu_frame_receiver_defines.svh"

module modbus_rtu_frame_receiver #(
	parameter int MaxFrame = mrtu_pkg::MAX_FRAME_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mrtu_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output mrtu_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata
);

	localparam int CW = $clog2(MaxFrame + 1);

	localparam logic [1:0] MODE_INIT  = 2'd0;
	localparam logic [1:0] MODE_IDLE  = 2'd1;
	localparam logic [1:0] MODE_RCV   = 2'd2;
	localparam logic [1:0] MODE_ERROR = 2'd3;

	logic [1:0]     mode_q;
	logic [CW-1:0]  count_q;
	logic [15:0]    crc_q;
	logic [7:0]     addr_q;
	logic [7:0]     func_q;
	logic [7:0]     own_addr_q;
	logic           out_valid_q;
	mrtu_pkg::out_t out_data_q;
	mrtu_pkg::out_t result;
	logic           accept;
	logic           ends_frame;
	logic           produce;
	logic           short_out;

	assign ends_frame = in_data.action && (mode_q == MODE_RCV);
	assign in_ready   = !out_valid_q || out_ready || !ends_frame;
	assign accept     = in_valid && in_ready;
	assign produce    = accept && ends_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= mrtu_pkg::OWN_ADDR_RST;
		end else if (cfg_we) begin
			own_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_INIT;
			count_q <= '0;
			crc_q   <= mrtu_pkg::CRC_INIT;
			addr_q  <= '0;
			func_q  <= '0;
		end else if (accept) begin
			if (!in_data.action) begin
				unique case (mode_q) inside
					MODE_IDLE: begin
						count_q <= CW'(1);
						crc_q   <= mrtu_pkg::crc16_byte(mrtu_pkg::CRC_INIT, in_data.rx_byte);
						addr_q  <= in_data.rx_byte;
						func_q  <= '0;
						mode_q  <= MODE_RCV;
					end
					MODE_RCV: begin
						if (count_q < CW'(MaxFrame)) begin
							if (count_q == CW'(1)) begin
								func_q <= in_data.rx_byte;
							end
							count_q <= count_q + CW'(1);
							crc_q   <= mrtu_pkg::crc16_byte(crc_q, in_data.rx_byte);
						end else begin
							mode_q <= MODE_ERROR;
						end
					end
					MODE_INIT, MODE_ERROR: begin
					end
				endcase
			end else begin
				unique case (mode_q) inside
					MODE_INIT, MODE_ERROR, MODE_RCV: begin
						mode_q <= MODE_IDLE;
					end
					MODE_IDLE: begin
					end
				endcase
			end
		end
	end

	mrtu_classify #(
		.CW(CW)
	) u_classify (
		.byte_count   (count_q),
		.running_crc  (crc_q),
		.held_address (addr_q),
		.held_function(func_q),
		.own_address  (own_addr_q),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign short_out = out_valid_q && (out_data_q.status == mrtu_pkg::ST_TOO_SHORT);

	`MRTU_ASSERT_NEXT(a_result_follows, produce, out_valid_q)
	`MRTU_ASSERT_NOW(a_error_at_limit, mode_q == MODE_ERROR, count_q == CW'(MaxFrame))
	`MRTU_ASSERT_NOW(a_rcv_counts, mode_q == MODE_RCV, count_q != '0)
	`MRTU_ASSERT_NOW(a_short_no_pdu, short_out, out_data_q.pdu_length == 8'd0)

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench for the Modbus RTU frame receiver: byte and silence-timeout transactions
// go in, frame results are checked against a local CRC-16 frame tracker.
// Depends on mrtu_pkg and modbus_rtu_frame_receiver.
module tb;

	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_TIMEOUT = 1'b1;
	localparam int   SETTLE      = 4;
	localparam int   HOLD_CYCLES = 300;
	localparam int   CYCLE_LIMIT = 600000;
	localparam int   ITEM_TARGET = 750;

	typedef enum logic [1:0] {
		LINE_STARTUP,
		LINE_QUIET,
		LINE_FRAME,
		LINE_DISCARD
	} line_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	mrtu_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	mrtu_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = mrtu_pkg::OWN_ADDR_RST;

	line_mode_t line_mode = LINE_STARTUP;
	logic [8:0] frame_len = '0;
	logic [15:0] frame_crc = mrtu_pkg::CRC_INIT;
	logic [7:0] frame_addr = '0;
	logic [7:0] frame_func = '0;
	logic [7:0] own_addr_model = mrtu_pkg::OWN_ADDR_RST;

	mrtu_pkg::out_t frame_results_due[$];
	int fail_count = 0;
	int items_sent = 0;
	int cycle_count = 0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	bit hold_req = 1'b0;

	modbus_rtu_frame_receiver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		r = {acc[15:8], acc[7:0] ^ b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ({1'b0, r[15:1]} ^ mrtu_pkg::CRC_POLY) : {1'b0, r[15:1]};
		end
		return r;
	endfunction

	// Applies one accepted transaction to the local copy of the receive state.
	task automatic follow_line(input mrtu_pkg::in_t it);
		mrtu_pkg::out_t res;
		if (it.action == ACT_BYTE) begin
			case (line_mode)
				LINE_QUIET: begin
					frame_len = 9'd1;
					frame_crc = crc_fold(mrtu_pkg::CRC_INIT, it.rx_byte);
					frame_addr = it.rx_byte;
					frame_func = 8'h00;
					line_mode = LINE_FRAME;
				end
				LINE_FRAME: begin
					if (frame_len < 9'(mrtu_pkg::MAX_FRAME_DEF)) begin
						if (frame_len == 9'd1) begin
							frame_func = it.rx_byte;
						end
						frame_len = frame_len + 9'd1;
						frame_crc = crc_fold(frame_crc, it.rx_byte);
					end else begin
						line_mode = LINE_DISCARD;
					end
				end
				default: begin
				end
			endcase
		end else if (line_mode == LINE_FRAME) begin
			res.frame_address = frame_addr;
			res.function_code = frame_func;
			res.is_broadcast = (frame_addr == mrtu_pkg::BCAST_ADDR);
			if (frame_len < 9'(mrtu_pkg::MIN_FRAME)) begin
				res.status = mrtu_pkg::ST_TOO_SHORT;
				res.pdu_length = 8'h00;
			end else begin
				res.pdu_length = 8'(frame_len - 9'(mrtu_pkg::HDR_CRC_BYTES));
				if (frame_crc != 16'h0000) begin
					res.status = mrtu_pkg::ST_CRC_ERROR;
				end else if (frame_addr != own_addr_model
						&& frame_addr != mrtu_pkg::BCAST_ADDR) begin
					res.status = mrtu_pkg::ST_NOT_ADDR;
				end else begin
					res.status = mrtu_pkg::ST_ACCEPTED;
				end
			end
			frame_results_due.push_back(res);
			line_mode = LINE_QUIET;
		end else begin
			line_mode = LINE_QUIET;
		end
	endtask

	// Valid is only lowered when a gap follows, so back-to-back transactions keep it high.
	task automatic send_item(input logic act, input logic [7:0] b);
		mrtu_pkg::in_t it;
		int gap;
		it.action = act;
		it.rx_byte = b;
		gap = send_idle ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		follow_line(it);
		items_sent++;
	endtask

	// Frames of four bytes or more carry a CRC, which is spoilt by one bit flip on request.
	task automatic send_frame(input logic [7:0] addr, input logic [7:0] fcode,
			input int n_bytes, input bit good_crc);
		logic [7:0] bytes_q[$];
		logic [15:0] acc;
		int pos;
		bytes_q.push_back(addr);
		while (bytes_q.size() < n_bytes) begin
			bytes_q.push_back((bytes_q.size() == 1) ? fcode : 8'($urandom));
		end
		if (n_bytes >= mrtu_pkg::MIN_FRAME) begin
			acc = mrtu_pkg::CRC_INIT;
			for (int i = 0; i < n_bytes - 2; i++) begin
				acc = crc_fold(acc, bytes_q[i]);
			end
			bytes_q[n_bytes - 2] = acc[7:0];
			bytes_q[n_bytes - 1] = acc[15:8];
			if (!good_crc) begin
				pos = $urandom_range(0, n_bytes - 1);
				bytes_q[pos] = bytes_q[pos] ^ 8'(1 << $urandom_range(0, 7));
			end
		end
		foreach (bytes_q[i]) begin
			send_item(ACT_BYTE, bytes_q[i]);
		end
		send_item(ACT_TIMEOUT, 8'($urandom));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (frame_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_own_address(input logic [7:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		own_addr_model = v;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		mrtu_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_results_due.size() == 0) begin
				$display("%0t: unexpected frame result, expected none, got %h",
					$time, out_data);
				fail_count++;
			end else begin
				want = frame_results_due.pop_front();
				compare_field("status", 8'(want.status), 8'(out_data.status));
				compare_field("frame_address", want.frame_address, out_data.frame_address);
				compare_field("function_code", want.function_code, out_data.function_code);
				compare_field("pdu_length", want.pdu_length, out_data.pdu_length);
				compare_field("is_broadcast", 8'(want.is_broadcast),
					8'(out_data.is_broadcast));
			end
		end
	end

	initial begin : result_sink
		int stall;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = recv_idle ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid || hold_req));
		end
	end

	task automatic test_power_up();
		send_item(ACT_BYTE, 8'h5A);
		send_item(ACT_TIMEOUT, 8'h00);
		send_item(ACT_TIMEOUT, 8'hFF);
		send_frame(mrtu_pkg::OWN_ADDR_RST, 8'h03, 4, 1'b1);
		drain_results();
	endtask

	task automatic test_short_frames();
		send_frame(mrtu_pkg::OWN_ADDR_RST, 8'h00, 1, 1'b1);
		send_frame(8'hFF, 8'hFF, 2, 1'b1);
		send_frame(mrtu_pkg::BCAST_ADDR, 8'h00, 3, 1'b0);
		drain_results();
	endtask

	task automatic test_frame_checks();
		send_frame(mrtu_pkg::BCAST_ADDR, 8'hFF, 6, 1'b1);
		send_frame(8'hFF, 8'h00, 5, 1'b1);
		send_frame(mrtu_pkg::OWN_ADDR_RST, 8'h10, 8, 1'b0);
		send_frame(mrtu_pkg::BCAST_ADDR, 8'h06, 4, 1'b0);
		drain_results();
	endtask

	task automatic test_length_limit();
		send_frame(own_addr_model, 8'h10, mrtu_pkg::MAX_FRAME_DEF, 1'b1);
		send_frame(own_addr_model, 8'h17, mrtu_pkg::MAX_FRAME_DEF + 3, 1'b1);
		send_frame(mrtu_pkg::BCAST_ADDR, 8'h05, 5, 1'b1);
		drain_results();
	endtask

	task automatic test_own_address();
		write_own_address(8'd247);
		send_frame(8'd247, 8'h03, 6, 1'b1);
		send_frame(8'd1, 8'h03, 6, 1'b1);
		drain_results();
		write_own_address(8'h80);
		send_frame(8'h80, 8'h04, 4, 1'b1);
		drain_results();
		write_own_address(8'd1);
		send_frame(8'd1, 8'h01, 5, 1'b1);
		send_frame(8'd247, 8'h01, 5, 1'b1);
		drain_results();
	endtask

	task automatic test_backpressure();
		send_idle = 1'b0;
		hold_req = 1'b1;
		repeat (12) send_frame(own_addr_model, 8'($urandom), mrtu_pkg::MIN_FRAME, 1'b1);
		drain_results();
		send_idle = 1'b1;
	endtask

	task automatic test_random_traffic();
		int frames;
		int pick;
		int n;
		logic [7:0] addr;
		frames = 0;
		while (items_sent < ITEM_TARGET) begin
			if (frames % 4 == 0) begin
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle = ($urandom_range(0, 3) != 0);
			end
			if (frames % 8 == 7) begin
				drain_results();
				write_own_address(8'($urandom_range(1, 247)));
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 6)) send_item(1'($urandom), 8'($urandom));
			end else begin
				case ($urandom_range(0, 5))
					0, 1: addr = own_addr_model;
					2: addr = mrtu_pkg::BCAST_ADDR;
					default: addr = 8'($urandom);
				endcase
				pick = $urandom_range(0, 9);
				n = (pick < 7) ? $urandom_range(4, 10) :
					(pick < 9) ? $urandom_range(11, 40) : $urandom_range(1, 3);
				send_frame(addr, 8'($urandom), n, $urandom_range(0, 99) >= 15);
			end
			frames++;
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_up();
		test_short_frames();
		test_frame_checks();
		test_length_limit();
		test_own_address();
		test_backpressure();
		test_random_traffic();
		drain_results();
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
